// ===== rtl/ple_pkg.sv =====
// shared types and constants of the positional list engine
package ple_pkg;

  // field widths of one input item and one result item
  localparam int unsigned CMD_W    = 3;
  localparam int unsigned POS_W    = 5;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned IDX_W    = 4;
  localparam int unsigned CNT_W    = 5;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 48;

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT   = 3'd0,
    CMD_DELETE   = 3'd1,
    CMD_LOCATE   = 3'd2,
    CMD_RETRIEVE = 3'd3,
    CMD_NEXT     = 3'd4,
    CMD_PREV     = 3'd5
  } cmd_code_e;

  // source of the reported index
  typedef enum logic [1:0] {
    IDX_NONE    = 2'd0,
    IDX_TGT     = 2'd1,
    IDX_POS_INC = 2'd2,
    IDX_POS_DEC = 2'd3
  } idx_sel_e;

  // commands from controller to datapath
  typedef struct packed {
    logic     capture;
    logic     start;
    logic     rd_up;
    logic     rd_dn;
    logic     rd_at;
    logic     wr_shift;
    logic     wr_val;
    logic     cnt_inc;
    logic     cnt_dec;
    logic     stg_ok;
    logic     stg_val;
    idx_sel_e idx_sel;
    logic     res_ld;
  } dp_ctrl_t;

  // status from datapath to controller
  typedef struct packed {
    cmd_code_e cmd;
    logic      ins_ok;
    logic      rd_ok;
    logic      next_ok;
    logic      prev_ok;
    logic      more_up;
    logic      more_dn;
    logic      more_at;
    logic      pend;
    logic      match;
  } dp_stat_t;

endpackage

// ===== rtl/ple_datapath.sv =====
// datapath of the positional list engine: entry store, count, walk pointer, results
module ple_datapath #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [ple_pkg::CMD_W-1:0]    command_i,
  input  logic [ple_pkg::POS_W-1:0]    position_i,
  input  logic [ple_pkg::VAL_W-1:0]    value_i,
  input  ple_pkg::dp_ctrl_t            ctrl_i,
  output ple_pkg::dp_stat_t            stat_o,
  output logic                         ok_o,
  output logic [ple_pkg::VAL_W-1:0]    item_value_o,
  output logic [ple_pkg::IDX_W-1:0]    item_index_o,
  output logic [ple_pkg::CNT_W-1:0]    entry_count_o,
  output logic                         is_empty_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned EW = ((CW > ple_pkg::POS_W) ? CW : ple_pkg::POS_W) + 1;

  logic [ple_pkg::VAL_W-1:0] mem [CAPACITY];

  logic [ple_pkg::CMD_W-1:0] cmd_q;
  logic [ple_pkg::POS_W-1:0] pos_q;
  logic [ple_pkg::VAL_W-1:0] val_q;
  logic [CW-1:0]             cnt_q, cnt_d;
  logic [CW-1:0]             idx_q, idx_d;
  logic                      pend_q;
  logic [AW-1:0]             tgt_q;
  logic [ple_pkg::VAL_W-1:0] rdata_q;

  logic                      stg_ok_q;
  logic [ple_pkg::VAL_W-1:0] stg_val_q;
  logic [ple_pkg::IDX_W-1:0] stg_idx_q, stg_idx_d;

  logic                      ok_q;
  logic [ple_pkg::VAL_W-1:0] item_value_q;
  logic [ple_pkg::IDX_W-1:0] item_index_q;
  logic [ple_pkg::CNT_W-1:0] count_q;
  logic                      empty_q;

  logic [EW-1:0] pos_e, cnt_e, idx_e, tgt_e, pos_inc_e, pos_dec_e, rd_addr_e;
  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [ple_pkg::VAL_W-1:0] wr_data;

  // extended operands for compares
  assign pos_e     = EW'(pos_q);
  assign cnt_e     = EW'(cnt_q);
  assign idx_e     = EW'(idx_q);
  assign tgt_e     = EW'(tgt_q);
  assign pos_inc_e = pos_e + EW'(1);
  assign pos_dec_e = pos_e - EW'(1);

  // status towards the controller
  always_comb begin
    stat_o.cmd     = ple_pkg::cmd_code_e'(cmd_q);
    stat_o.ins_ok  = (pos_e <= cnt_e) && (cnt_e < EW'(CAPACITY));
    stat_o.rd_ok   = pos_e < cnt_e;
    stat_o.next_ok = pos_inc_e < cnt_e;
    stat_o.prev_ok = (pos_e != '0) && (pos_e < cnt_e);
    stat_o.more_up = idx_e > pos_e;
    stat_o.more_dn = (idx_e + EW'(1)) < cnt_e;
    stat_o.more_at = idx_e < cnt_e;
    stat_o.pend    = pend_q;
    stat_o.match   = pend_q && (rdata_q == val_q);
  end

  // read and write port selection
  always_comb begin
    rd_en = ctrl_i.rd_up || ctrl_i.rd_dn || ctrl_i.rd_at;
    if (ctrl_i.rd_up) begin
      rd_addr_e = idx_e - EW'(1);
    end else if (ctrl_i.rd_dn) begin
      rd_addr_e = idx_e + EW'(1);
    end else begin
      rd_addr_e = idx_e;
    end
    rd_addr = rd_addr_e[AW-1:0];
    wr_en   = ctrl_i.wr_shift || ctrl_i.wr_val;
    wr_addr = ctrl_i.wr_val ? pos_e[AW-1:0] : tgt_q;
    wr_data = ctrl_i.wr_val ? val_q : rdata_q;
  end

  // walk pointer and count
  always_comb begin
    idx_d = idx_q;
    if (ctrl_i.start) begin
      case (ple_pkg::cmd_code_e'(cmd_q))
        ple_pkg::CMD_INSERT: idx_d = cnt_q;
        ple_pkg::CMD_LOCATE: idx_d = '0;
        default:             idx_d = pos_e[CW-1:0];
      endcase
    end else if (ctrl_i.rd_up) begin
      idx_d = idx_q - CW'(1);
    end else if (ctrl_i.rd_dn || ctrl_i.rd_at) begin
      idx_d = idx_q + CW'(1);
    end
    cnt_d = cnt_q;
    if (ctrl_i.cnt_inc) begin
      cnt_d = cnt_q + CW'(1);
    end else if (ctrl_i.cnt_dec) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  // reported index source
  always_comb begin
    case (ctrl_i.idx_sel)
      ple_pkg::IDX_TGT:     stg_idx_d = tgt_e[ple_pkg::IDX_W-1:0];
      ple_pkg::IDX_POS_INC: stg_idx_d = pos_inc_e[ple_pkg::IDX_W-1:0];
      ple_pkg::IDX_POS_DEC: stg_idx_d = pos_dec_e[ple_pkg::IDX_W-1:0];
      default:              stg_idx_d = stg_idx_q;
    endcase
  end

  // entry store, one write and one registered read a cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      pend_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      pend_q <= rd_en;
    end
  end

  // captured item, pointer, staging and result registers
  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    if (rd_en) begin
      tgt_q <= idx_q[AW-1:0];
    end
    if (ctrl_i.capture) begin
      cmd_q     <= command_i;
      pos_q     <= position_i;
      val_q     <= value_i;
      stg_ok_q  <= 1'b0;
      stg_val_q <= '0;
      stg_idx_q <= '0;
    end else begin
      if (ctrl_i.stg_ok) begin
        stg_ok_q <= 1'b1;
      end
      if (ctrl_i.stg_val) begin
        stg_val_q <= rdata_q;
      end
      stg_idx_q <= stg_idx_d;
    end
    if (ctrl_i.res_ld) begin
      ok_q         <= stg_ok_q;
      item_value_q <= stg_val_q;
      item_index_q <= stg_idx_q;
      count_q      <= cnt_e[ple_pkg::CNT_W-1:0];
      empty_q      <= (cnt_q == '0);
    end
  end

  assign ok_o          = ok_q;
  assign item_value_o  = item_value_q;
  assign item_index_o  = item_index_q;
  assign entry_count_o = count_q;
  assign is_empty_o    = empty_q;

`ifndef SYNTHESIS
  // the count never passes the store size
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // a shift write and the new value never meet on the single write port
  a_wr_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl_i.wr_shift && ctrl_i.wr_val))
    else $error("write port collision");

  // the count moves by at most one per command
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != $past(cnt_q)) |->
      ((cnt_q == $past(cnt_q) + CW'(1)) || (cnt_q + CW'(1) == $past(cnt_q))))
    else $error("entry count jumped");
`endif

endmodule

// ===== rtl/ple_controller.sv =====
// controller of the positional list engine: sequences each command over the datapath
module ple_controller (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  ple_pkg::dp_stat_t  stat_i,
  output ple_pkg::dp_ctrl_t  ctrl_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_INS_SHIFT,
    ST_DEL_SHIFT,
    ST_LOC_SCAN,
    ST_RET_RD,
    ST_RET_WAIT,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   out_vld_q, out_vld_d;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_vld_q;

  // next state and datapath commands
  always_comb begin
    state_d        = state_q;
    ctrl_o         = '0;
    ctrl_o.idx_sel = ple_pkg::IDX_NONE;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          ctrl_o.capture = 1'b1;
          state_d        = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_d = ST_FINISH;
        case (stat_i.cmd)
          ple_pkg::CMD_INSERT: begin
            if (stat_i.ins_ok) begin
              ctrl_o.start = 1'b1;
              state_d      = ST_INS_SHIFT;
            end
          end
          ple_pkg::CMD_DELETE: begin
            if (stat_i.rd_ok) begin
              ctrl_o.start = 1'b1;
              state_d      = ST_DEL_SHIFT;
            end
          end
          ple_pkg::CMD_LOCATE: begin
            ctrl_o.start = 1'b1;
            state_d      = ST_LOC_SCAN;
          end
          ple_pkg::CMD_RETRIEVE: begin
            if (stat_i.rd_ok) begin
              ctrl_o.start = 1'b1;
              state_d      = ST_RET_RD;
            end
          end
          ple_pkg::CMD_NEXT: begin
            if (stat_i.next_ok) begin
              ctrl_o.stg_ok  = 1'b1;
              ctrl_o.idx_sel = ple_pkg::IDX_POS_INC;
            end
          end
          ple_pkg::CMD_PREV: begin
            if (stat_i.prev_ok) begin
              ctrl_o.stg_ok  = 1'b1;
              ctrl_o.idx_sel = ple_pkg::IDX_POS_DEC;
            end
          end
          default: begin
            state_d = ST_FINISH;
          end
        endcase
      end
      // move entries up from the tail, then drop the new value in
      ST_INS_SHIFT: begin
        ctrl_o.rd_up    = stat_i.more_up;
        ctrl_o.wr_shift = stat_i.pend;
        if (!stat_i.more_up && !stat_i.pend) begin
          ctrl_o.wr_val  = 1'b1;
          ctrl_o.cnt_inc = 1'b1;
          ctrl_o.stg_ok  = 1'b1;
          state_d        = ST_FINISH;
        end
      end
      // move entries down over the removed one
      ST_DEL_SHIFT: begin
        ctrl_o.rd_dn    = stat_i.more_dn;
        ctrl_o.wr_shift = stat_i.pend;
        if (!stat_i.more_dn && !stat_i.pend) begin
          ctrl_o.cnt_dec = 1'b1;
          ctrl_o.stg_ok  = 1'b1;
          state_d        = ST_FINISH;
        end
      end
      // compare entries in order, stop at the first match
      ST_LOC_SCAN: begin
        if (stat_i.match) begin
          ctrl_o.stg_ok  = 1'b1;
          ctrl_o.idx_sel = ple_pkg::IDX_TGT;
          state_d        = ST_FINISH;
        end else if (stat_i.more_at) begin
          ctrl_o.rd_at = 1'b1;
        end else if (!stat_i.pend) begin
          state_d = ST_FINISH;
        end
      end
      ST_RET_RD: begin
        ctrl_o.rd_at = 1'b1;
        state_d      = ST_RET_WAIT;
      end
      ST_RET_WAIT: begin
        ctrl_o.stg_ok  = 1'b1;
        ctrl_o.stg_val = 1'b1;
        state_d        = ST_FINISH;
      end
      // hand the result to the output register once it is free
      ST_FINISH: begin
        if (!out_vld_q || out_ready_i) begin
          ctrl_o.res_ld = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // output valid follows loads and transfers
  always_comb begin
    if (ctrl_o.res_ld) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

endmodule

// ===== rtl/positional_list_engine_unit.sv =====
// Positional list engine: an ordered list of signed 32-bit values in a store of CAPACITY
// entries. Each command transfer yields one result transfer. Insert and delete move the
// entries between the position and the tail, locate compares entries from the head,
// retrieve reads one entry, and next or previous index, like any command that fails its
// bounds check, needs no access to the store. The engine passes back through idle before
// the next command is taken. How long a command lasts is set by the walk over the entry
// store, which has one read and one write port, so entries are moved or compared one per
// cycle. A finished result waits in the output register while the next command is accepted.
// No clearing pass follows reset.
module positional_list_engine_unit #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // command [2:0], position [7:3], value [39:8]
  input  logic [ple_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // ok [0], item_value [32:1], item_index [36:33], entry_count [41:37], is_empty [42],
  // zero [47:43]
  output logic [ple_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

  ple_pkg::dp_ctrl_t ctrl;
  ple_pkg::dp_stat_t stat;

  logic                          ok;
  logic [ple_pkg::VAL_W-1:0]     item_value;
  logic [ple_pkg::IDX_W-1:0]     item_index;
  logic [ple_pkg::CNT_W-1:0]     entry_count;
  logic                          is_empty;

  // command sequencer
  ple_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  // store, count and result registers
  ple_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .command_i     (s_axis_tdata[2:0]),
    .position_i    (s_axis_tdata[7:3]),
    .value_i       (s_axis_tdata[39:8]),
    .ctrl_i        (ctrl),
    .stat_o        (stat),
    .ok_o          (ok),
    .item_value_o  (item_value),
    .item_index_o  (item_index),
    .entry_count_o (entry_count),
    .is_empty_o    (is_empty)
  );

  // pack the result transfer
  assign m_axis_tdata = {5'b0, is_empty, entry_count, item_index, item_value, ok};

endmodule
